// File: hw/rtl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types and constants for the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;
	localparam int CmmMaxN = 8;

	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// datapath commands from the controller
	typedef struct packed {
		logic clear;    // clear accumulators
		logic rd;       // issue a read of A/B entries
		logic mac_a;    // products of previous read valid
		logic out_load; // round/saturate into output register
	} cmm_cmd_t;

	typedef struct packed {
		logic out_full; // output register holds a transaction
		logic out_take; // output transaction accepted this cycle
	} cmm_sts_t;
endpackage

// File: hw/rtl/cmm_stream_if.sv
// ----------------------------------------------------------------------------
// cmm_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface cmm_stream_if #(parameter int W = 66);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/cmm_ctrl.sv
// ----------------------------------------------------------------------------
// cmm_ctrl
// Controller: load counters, compute sequencer (i, j, k loops).
// ----------------------------------------------------------------------------
module cmm_ctrl #(
	parameter int MAX_N = cmm_pkg::CmmMaxN,
	parameter int IW    = $clog2(MAX_N*MAX_N),
	parameter int NW    = $clog2(MAX_N+1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        size_in_use,
	input  logic              in_valid,
	input  logic [1:0]        in_command,
	output logic              in_ready,
	output logic              wr_a,
	output logic              wr_b,
	output logic [IW-1:0]     wr_addr,
	output logic [IW-1:0]     rd_a_addr,
	output logic [IW-1:0]     rd_b_addr,
	output logic              last_tag,
	output cmm_pkg::cmm_cmd_t cmd,
	input  cmm_pkg::cmm_sts_t sts
);
	import cmm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam int TW = $clog2(MAX_N*MAX_N+1);

	logic [1:0]    state_q;
	logic [TW-1:0] a_cnt_q, b_cnt_q, total;
	logic [NW-1:0] n, i_q, j_q, k_q;
	logic          mac_s1, mac_s2;
	logic          acc;

	always_comb begin
		if (size_in_use == 4'd0) n = NW'(1);
		else if (32'(size_in_use) > MAX_N) n = NW'(MAX_N);
		else n = NW'(size_in_use);
	end
	assign total = TW'(n) * TW'(n);

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;
	assign wr_a = acc && in_command == CMD_LOAD_A && a_cnt_q < total;
	assign wr_b = acc && in_command == CMD_LOAD_B && b_cnt_q < total;
	assign wr_addr = (in_command == CMD_LOAD_A) ? IW'(a_cnt_q) : IW'(b_cnt_q);

	assign rd_a_addr = IW'(32'(i_q) * 32'(n) + 32'(k_q));
	assign rd_b_addr = IW'(32'(k_q) * 32'(n) + 32'(j_q));
	// element being loaded into the output register is the final one
	assign last_tag = (i_q == n - 1'b1) && (j_q == n - 1'b1);

	always_comb begin
		cmd = '0;
		cmd.clear = acc && in_command == CMD_COMPUTE;
		cmd.rd = (state_q == ST_MAC);
		cmd.mac_a = mac_s2;
		cmd.out_load = (state_q == ST_OUT) && (!sts.out_full || sts.out_take);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			mac_s1 <= cmd.rd;
			mac_s2 <= mac_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (wr_a) a_cnt_q <= a_cnt_q + 1'b1;
					if (wr_b) b_cnt_q <= b_cnt_q + 1'b1;
					if (cmd.clear) begin
						a_cnt_q <= '0;
						b_cnt_q <= '0;
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q == n - 1'b1) begin
						k_q <= '0;
						state_q <= ST_WAIT;
					end else k_q <= k_q + 1'b1;
				end
				ST_WAIT: if (!mac_s1 && !mac_s2) state_q <= ST_OUT;
				ST_OUT: begin
					if (cmd.out_load) begin
						if (j_q == n - 1'b1) begin
							j_q <= '0;
							if (i_q == n - 1'b1) state_q <= ST_IDLE;
							else begin
								i_q <= i_q + 1'b1;
								state_q <= ST_MAC;
							end
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/cmm_datapath.sv
// ----------------------------------------------------------------------------
// cmm_datapath
// A/B memories, four multipliers, two accumulators, round/saturate, output reg.
// ----------------------------------------------------------------------------
module cmm_datapath #(
	parameter int MAX_N = cmm_pkg::CmmMaxN,
	parameter int IW    = $clog2(MAX_N*MAX_N)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_a,
	input  logic              wr_b,
	input  logic [IW-1:0]     wr_addr,
	input  logic [63:0]       wr_data,
	input  logic [IW-1:0]     rd_a_addr,
	input  logic [IW-1:0]     rd_b_addr,
	input  logic              last_tag,
	input  cmm_pkg::cmm_cmd_t cmd,
	output cmm_pkg::cmm_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_re,
	output logic [31:0]       out_im,
	output logic              out_last
);
	import cmm_pkg::*;

	localparam int AW = 64 + $clog2(2*MAX_N+1) + 1;

	logic [63:0] mem_a [MAX_N*MAX_N];
	logic [63:0] mem_b [MAX_N*MAX_N];
	logic [63:0] a_s1, b_s1;
	logic signed [63:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [AW-1:0] re_q, im_q;
	logic [31:0] re_o_q, im_o_q;
	logic last_o_q, full_q;

	always_ff @(posedge clk) begin
		if (wr_a) mem_a[wr_addr] <= wr_data;
		if (wr_b) mem_b[wr_addr] <= wr_data;
		a_s1 <= mem_a[rd_a_addr];
		b_s1 <= mem_b[rd_b_addr];
		rr_s2 <= $signed(a_s1[31:0])  * $signed(b_s1[31:0]);
		ii_s2 <= $signed(a_s1[63:32]) * $signed(b_s1[63:32]);
		ri_s2 <= $signed(a_s1[31:0])  * $signed(b_s1[63:32]);
		ir_s2 <= $signed(a_s1[63:32]) * $signed(b_s1[31:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.clear || cmd.out_load) begin
			re_q <= '0;
			im_q <= '0;
		end else if (cmd.mac_a) begin
			re_q <= re_q + AW'(rr_s2) - AW'(ii_s2);
			im_q <= im_q + AW'(ri_s2) + AW'(ir_s2);
		end
	end

	function automatic logic [31:0] rsat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		logic signed [AW-17:0] s;
		begin
			r = v + AW'(32768);
			s = r[AW-1:16];
			if (s > $signed((AW-16)'(32'h7FFFFFFF))) rsat = 32'h7FFFFFFF;
			else if (s < -$signed((AW-16)'(33'h080000000))) rsat = 32'h80000000;
			else rsat = s[31:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			re_o_q <= rsat(re_q);
			im_o_q <= rsat(im_q);
			last_o_q <= last_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (cmd.out_load) full_q <= 1'b1;
		else if (out_ready) full_q <= 1'b0;
	end

	assign out_valid = full_q;
	assign out_re = re_o_q;
	assign out_im = im_o_q;
	assign out_last = last_o_q;
	assign sts.out_full = full_q;
	assign sts.out_take = full_q && out_ready;
endmodule

// File: hw/rtl/complex_matrix_multiply.sv
// ----------------------------------------------------------------------------
// complex_matrix_multiply
// C = A*B on complex Q16.16 square matrices, n up to MAX_N.
// ----------------------------------------------------------------------------
// channel   dir  payload [65:0]
// in_ch     in   {elem_im, elem_re, command}  [1:0] cmd, [33:2] re, [65:34] im
// out_ch    out  {last, prod_im, prod_re, 0}  [0] pad, [32:1] re, [64:33] im, [65] last
// cfg       in   cfg_we / cfg_data (size_in_use)
//
// Loads are accepted while ready is high. A compute issues n MAC reads per C
// element, drains the registered memory read and multiplier stages, then
// loads the output register; ready stays low until the last element is
// loaded. A stalled output register holds the sequencer. Reset clears
// counters and control; the memories are not cleared.
module complex_matrix_multiply #(
	parameter int MAX_N = cmm_pkg::CmmMaxN
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [3:0] cfg_data,
	cmm_stream_if.sink   in_ch,
	cmm_stream_if.source out_ch
);
	import cmm_pkg::*;

	localparam int IW = (MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1;

	logic [3:0] size_q;
	logic wr_a, wr_b, last_tag;
	logic [IW-1:0] wr_addr, rd_a_addr, rd_b_addr;
	cmm_cmd_t cmd;
	cmm_sts_t sts;
	logic [31:0] o_re, o_im;
	logic o_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= 4'd8;
		else if (cfg_we) size_q <= cfg_data;
	end

	cmm_ctrl #(.MAX_N(MAX_N), .IW(IW)) u_ctrl (
		.clk, .arst_n, .size_in_use(size_q),
		.in_valid(in_ch.valid), .in_command(in_ch.data[1:0]), .in_ready(in_ch.ready),
		.wr_a, .wr_b, .wr_addr, .rd_a_addr, .rd_b_addr, .last_tag, .cmd, .sts
	);

	cmm_datapath #(.MAX_N(MAX_N), .IW(IW)) u_dp (
		.clk, .arst_n, .wr_a, .wr_b, .wr_addr, .wr_data(in_ch.data[65:2]),
		.rd_a_addr, .rd_b_addr, .last_tag, .cmd, .sts,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_re(o_re), .out_im(o_im), .out_last(o_last)
	);

	assign out_ch.data = {o_last, o_im, o_re, 1'b0};
endmodule

// File: hw/rtl/cmm_checker.sv
// ----------------------------------------------------------------------------
// cmm_checker
// Port-level checks for complex_matrix_multiply.
// ----------------------------------------------------------------------------
module cmm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [65:0] out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output dropped under stall");
	// mid-matrix result pending means the sequencer is still busy
	a_busy_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data[65] |-> !in_ready)
		else $error("input ready during emit");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input transaction withdrawn");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data))
		else $error("unknown output payload");
endmodule

bind complex_matrix_multiply cmm_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Load/compute traffic for the complex matrix multiplier, with every C
// element checked against an in-bench fixed-point model of C = A*B or typed values.
// ----------------------------------------------------------------------------
module testbench;
	import cmm_pkg::*;

	// command 3 is unused by the block: it must be swallowed silently
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STORE_DEPTH = CmmMaxN * CmmMaxN;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int TARGET_ITEMS = 210;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        last;
	} c_elem_t;

	// directed row: typed result only for single-element (n = 1) computes
	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] re;
		logic [31:0] im;
		bit          typed;
		logic [31:0] exp_re;
		logic [31:0] exp_im;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_data = 4'd0;

	cmm_stream_if in_ch ();
	cmm_stream_if out_ch ();

	complex_matrix_multiply dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- shadow state of the multiplier ----
	logic [63:0] shadow_a [STORE_DEPTH];
	logic [63:0] shadow_b [STORE_DEPTH];
	bit          a_written [STORE_DEPTH];
	bit          b_written [STORE_DEPTH];
	int          a_fill;
	int          b_fill;
	logic [3:0]  shadow_size;

	c_elem_t expected_c [$];
	int      error_count = 0;
	int      items_sent = 0;
	int      cycle_count = 0;
	bit      hold_armed = 1'b0;

	function automatic int dim_now();
		if (shadow_size == 4'd0)
			return 1;
		if (shadow_size > CmmMaxN)
			return CmmMaxN;
		return int'(shadow_size);
	endfunction

	// exact sum, then round half up and saturate to Q16.16
	function automatic logic [31:0] round_saturate(logic signed [127:0] acc);
		logic signed [127:0] r;
		r = (acc + 128'sd32768) >>> 16;
		if (r > 128'sd2147483647)
			return 32'h7FFF_FFFF;
		if (r < -128'sd2147483648)
			return 32'h8000_0000;
		return r[31:0];
	endfunction

	// update shadow state for one accepted transaction, queue C if computed
	task automatic absorb_item(input stim_row_t it);
		int n, total;
		logic signed [127:0] acc_re, acc_im;
		longint ar, ai, br, bi;
		c_elem_t e;
		n = dim_now();
		total = n * n;
		case (it.cmd)
			CMD_LOAD_A: if (a_fill < total) begin
				shadow_a[a_fill] = {it.im, it.re};
				a_written[a_fill] = 1'b1;
				a_fill++;
			end
			CMD_LOAD_B: if (b_fill < total) begin
				shadow_b[b_fill] = {it.im, it.re};
				b_written[b_fill] = 1'b1;
				b_fill++;
			end
			CMD_COMPUTE: begin
				a_fill = 0;
				b_fill = 0;
				for (int i = 0; i < n; i++) begin
					for (int j = 0; j < n; j++) begin
						acc_re = '0;
						acc_im = '0;
						for (int k = 0; k < n; k++) begin
							ar = longint'($signed(shadow_a[i*n+k][31:0]));
							ai = longint'($signed(shadow_a[i*n+k][63:32]));
							br = longint'($signed(shadow_b[k*n+j][31:0]));
							bi = longint'($signed(shadow_b[k*n+j][63:32]));
							acc_re = acc_re + 128'(ar * br) - 128'(ai * bi);
							acc_im = acc_im + 128'(ar * bi) + 128'(ai * br);
						end
						e.re = round_saturate(acc_re);
						e.im = round_saturate(acc_im);
						e.last = (i * n + j + 1 == total);
						if (it.typed) begin
							e.re = it.exp_re;
							e.im = it.exp_im;
						end
						expected_c.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endtask

	// ---- sender: bursts of random length, random gaps ----
	int burst_left = 0;

	task automatic send_item(input stim_row_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_ch.valid = 1'b1;
		in_ch.data = {it.im, it.re, it.cmd};
		do
			@(posedge clk);
		while (!in_ch.ready);
		absorb_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic stim_row_t mk(logic [1:0] cmd, logic [31:0] re, logic [31:0] im);
		stim_row_t r;
		r.cmd = cmd;
		r.re = re;
		r.im = im;
		r.typed = 1'b0;
		r.exp_re = '0;
		r.exp_im = '0;
		return r;
	endfunction

	function automatic stim_row_t mk_c(logic [31:0] exp_re, logic [31:0] exp_im);
		stim_row_t r;
		r = mk(CMD_COMPUTE, $urandom, $urandom);
		r.typed = 1'b1;
		r.exp_re = exp_re;
		r.exp_im = exp_im;
		return r;
	endfunction

	// data mix: full range, small magnitudes near 1.0, rails
	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2, 3: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh1_FFFF);
			4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return {{16{1'b0}}, 16'($urandom)};
		endcase
	endfunction

	function automatic bit all_written(int n);
		for (int x = 0; x < n * n; x++)
			if (!a_written[x] || !b_written[x])
				return 1'b0;
		return 1'b1;
	endfunction

	// register writes only when nothing is in flight
	task automatic write_size(input logic [3:0] v);
		in_ch.valid = 1'b0;
		while (expected_c.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow_size = v;
	endtask

	// one matrix pair: mostly well formed, sometimes noise or cut short
	task automatic run_sequence(input bit big_hold);
		int n, total;
		bit broken;
		logic [1:0] c;
		n = dim_now();
		total = n * n;
		broken = ($urandom_range(0, 5) == 0);
		while (a_fill < total || b_fill < total) begin
			if ($urandom_range(0, 19) == 0)
				send_item(mk(CMD_UNUSED, rand_part(), rand_part()));
			if (broken && $urandom_range(0, 7) == 0)
				break;
			if (a_fill >= total)
				c = CMD_LOAD_B;
			else if (b_fill >= total)
				c = CMD_LOAD_A;
			else
				c = $urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B;
			send_item(mk(c, rand_part(), rand_part()));
			// occasional extra load, which the block drops once that matrix is full
			if ($urandom_range(0, 15) == 0)
				send_item(mk($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B,
					rand_part(), rand_part()));
		end
		if (all_written(n)) begin
			hold_armed = big_hold;
			send_item(mk(CMD_COMPUTE, rand_part(), rand_part()));
		end
	endtask

	// ---- receiver: stall pattern plus one long hold-off ----
	initial begin
		int mode, hold_cnt;
		out_ch.ready = 1'b0;
		mode = 0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (cycle_count % 64 == 0)
				mode = $urandom_range(0, 2);
			if (hold_armed && out_ch.valid) begin
				hold_armed = 1'b0;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready = 1'b0;
			end else begin
				case (mode)
					0: out_ch.ready = 1'b1;
					1: out_ch.ready = ($urandom_range(0, 3) != 0);
					default: out_ch.ready = $urandom_range(0, 1);
				endcase
			end
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h @%0t", what, got, want, $realtime);
		error_count++;
	endtask

	// ---- checker: each result transaction against the oldest expectation ----
	always @(posedge clk) begin
		c_elem_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_c.size() == 0) begin
				report("unexpected result", out_ch.data[32:1], '0);
			end else begin
				e = expected_c.pop_front();
				if (out_ch.data[32:1] !== e.re)
					report("prod_re", out_ch.data[32:1], e.re);
				if (out_ch.data[64:33] !== e.im)
					report("prod_im", out_ch.data[64:33], e.im);
				if (out_ch.data[65] !== e.last)
					report("last", 32'(out_ch.data[65]), 32'(e.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---- stimulus ----
	stim_row_t directed [$];

	initial begin
		int wait_cnt;
		logic [3:0] size_plan [$];
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		shadow_size = 4'd8;
		a_fill = 0;
		b_fill = 0;
		foreach (a_written[x]) begin
			a_written[x] = 1'b0;
			b_written[x] = 1'b0;
			shadow_a[x] = '0;
			shadow_b[x] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at n = 1: single products, rails, rounding
		write_size(4'd1);
		directed = '{
			mk(CMD_LOAD_A, 32'h0001_0000, 32'h0),
			mk(CMD_LOAD_B, 32'h0001_0000, 32'h0),
			mk_c(32'h0001_0000, 32'h0),
			// both parts at the negative rail: im overflows high
			mk(CMD_LOAD_A, 32'h8000_0000, 32'h8000_0000),
			mk(CMD_LOAD_B, 32'h8000_0000, 32'h8000_0000),
			mk(CMD_LOAD_A, 32'h1234_5678, 32'h9ABC_DEF0), // past the end
			mk_c(32'h0, 32'h7FFF_FFFF),
			mk(CMD_LOAD_A, 32'h7FFF_FFFF, 32'h0),
			mk(CMD_LOAD_B, 32'h8000_0000, 32'h0),
			mk(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			mk_c(32'h8000_0000, 32'h0),
			// half an LSB rounds up; minus half rounds to zero
			mk(CMD_LOAD_A, 32'h0000_0001, 32'h0),
			mk(CMD_LOAD_B, 32'h0000_8000, 32'h0),
			mk_c(32'h0000_0001, 32'h0),
			mk(CMD_LOAD_A, 32'hFFFF_FFFF, 32'h0),
			mk(CMD_LOAD_B, 32'h0000_8000, 32'h0),
			mk_c(32'h0, 32'h0),
			mk(CMD_LOAD_B, 32'h7FFF_FFFF, 32'h8000_0000),
			mk(CMD_LOAD_A, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
			mk_c(32'h7FFF_FFFF, 32'hFFFF_8000)
		};
		foreach (directed[r])
			send_item(directed[r]);

		// random part: a planned size list first (including the clamped 0 and 15), then small matrices
		size_plan = '{4'd2, 4'd0, 4'd15, 4'd3};
		while (items_sent < TARGET_ITEMS || size_plan.size() != 0) begin
			if (size_plan.size() != 0)
				write_size(size_plan.pop_front());
			else
				write_size($urandom_range(0, 4));
			// a full-size matrix pair alone is over a hundred transactions
			repeat ((dim_now() == CmmMaxN) ? 1 : $urandom_range(1, 3))
				run_sequence(dim_now() == CmmMaxN);
			// strays after the compute: stalled against a busy block
			repeat ($urandom_range(0, 3))
				send_item(mk($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B,
					rand_part(), rand_part()));
			if (items_sent >= TARGET_ITEMS && size_plan.size() == 0)
				break;
		end
		in_ch.valid = 1'b0;

		wait_cnt = 0;
		while (expected_c.size() != 0 && wait_cnt < CYCLE_LIMIT) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_c.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results outstanding", error_count,
				expected_c.size());
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
